// ===== rtl/kfct_pkg.sv =====
// shared types and constants for the key frequency counter table
package kfct_pkg;

    localparam int unsigned CNT_W = 32;
    localparam int unsigned AMT_W = 16;
    localparam int unsigned THR_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word, reset scan
        logic scan_step;  // present next entry address
        logic scan_eval;  // evaluate registered entry data
        logic wr_key;     // write key to insert slot
        logic wr_cnt;     // write updated count to hit or insert slot
        logic upd;        // set used bit, update total and best
        logic decide;     // settle result count and flags
        logic dom_mul;    // start dominance product
        logic out_load;   // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic hit;
        logic is_add;
        logic has_free;
    } t_sts;

endpackage

// ===== rtl/kfct_if.sv =====
// valid/ready channel interface
interface kfct_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/kfct_ram.sv =====
// generic single-port write, single-port read ram with registered read
module kfct_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/kfct_ctrl.sv =====
// sequencer for scan, update and result stages
module kfct_ctrl import kfct_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_EVAL = 7'b0000100,
        S_UPD  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // one entry read per cycle; the last read's data arrives in the following cycle
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.scan_eval = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.decide = 1'b1;
                if (i_sts.is_add && (i_sts.hit || i_sts.has_free)) begin
                    o_cmd.upd    = 1'b1;
                    o_cmd.wr_key = !i_sts.hit;
                    o_cmd.wr_cnt = 1'b1;
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.dom_mul = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped");
    a_wr_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_cnt |-> o_cmd.upd && r_state == S_UPD)
        else $error("write outside update");
endmodule

// ===== rtl/kfct_dp.sv =====
// table memories, scan compare, saturating update and dominance test
module kfct_dp import kfct_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_req_type,
    input  logic [31:0]        i_key,
    input  logic [AMT_W-1:0]   i_amount,
    input  logic [THR_W-1:0]   i_thr,
    output logic [CNT_W-1:0]   o_key_count,
    output logic [CNT_W-1:0]   o_total_count,
    output logic [31:0]        o_top_key,
    output logic [CNT_W-1:0]   o_top_count,
    output logic               o_top_valid,
    output logic               o_top_dominant,
    output logic               o_table_full,
    output logic               o_saturated
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;

    logic [TABLE_ENTRIES-1:0] r_used;
    logic [AW-1:0]            r_addr, r_eval_addr, r_hit_addr, r_free_addr;
    logic [CW-1:0]            r_evaled;
    logic                     r_hit, r_has_free;
    logic                     r_req;
    logic [KEY_BITS-1:0]      r_key;
    logic [AMT_W-1:0]         r_amt;
    logic [CNT_W-1:0]         r_hit_cnt;
    logic [CNT_W-1:0]         r_total, r_best_cnt;
    logic [KEY_BITS-1:0]      r_best_key;
    logic [CNT_W-1:0]         r_kc;
    logic                     r_full, r_clip;
    logic [CNT_W+THR_W-1:0]   r_rhs;
    logic [KEY_BITS-1:0]      w_rkey;
    logic [CNT_W-1:0]         w_rcnt;
    logic [AW-1:0]            w_waddr;
    logic [CNT_W:0]           w_csum, w_tsum;
    logic [CNT_W-1:0]         w_cnew, w_tnew, w_base;
    logic [KEY_BITS-1:0]      w_key_in;
    logic [31:0]              w_top_key;

    always_comb begin
        w_key_in = '0;
        w_key_in[KW-1:0] = i_key[KW-1:0];
    end

    always_comb begin
        w_top_key = '0;
        w_top_key[KW-1:0] = r_best_key[KW-1:0];
    end

    assign w_waddr = r_hit ? r_hit_addr : r_free_addr;
    assign w_base  = r_hit ? r_hit_cnt : '0;
    assign w_csum  = {1'b0, w_base} + {{(CNT_W-AMT_W+1){1'b0}}, r_amt};
    assign w_cnew  = w_csum[CNT_W] ? CNT_MAX : w_csum[CNT_W-1:0];
    assign w_tsum  = {1'b0, r_total} + {{(CNT_W-AMT_W+1){1'b0}}, r_amt};
    assign w_tnew  = w_tsum[CNT_W] ? CNT_MAX : w_tsum[CNT_W-1:0];

    kfct_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(i_cmd.wr_key), .i_waddr(w_waddr), .i_wdata(r_key),
        .i_raddr(r_addr), .o_rdata(w_rkey)
    );
    kfct_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES)) u_cnts (
        .i_clk(i_clk), .i_we(i_cmd.wr_cnt), .i_waddr(w_waddr), .i_wdata(w_cnew),
        .i_raddr(r_addr), .o_rdata(w_rcnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_total    <= '0;
            r_best_cnt <= '0;
            r_best_key <= '0;
        end else if (i_cmd.upd) begin
            r_used[w_waddr] <= 1'b1;
            r_total         <= w_tnew;
            if (w_cnew > r_best_cnt) begin
                r_best_cnt <= w_cnew;
                r_best_key <= r_key;
            end
        end
    end

    // sequential scan: address issued, data compared next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_req_type;
            r_key      <= w_key_in;
            r_amt      <= i_amount;
            r_addr     <= '0;
            r_evaled   <= '0;
            r_hit      <= 1'b0;
            r_has_free <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_eval_addr <= r_addr;
            r_addr      <= r_addr + AW'(1);
        end
        if (i_cmd.scan_eval) begin
            r_evaled <= r_evaled + CW'(1);
            if (r_used[r_eval_addr] && w_rkey == r_key && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_addr <= r_eval_addr;
                r_hit_cnt  <= w_rcnt;
            end
            if (!r_used[r_eval_addr] && !r_has_free) begin
                r_has_free  <= 1'b1;
                r_free_addr <= r_eval_addr;
            end
        end
    end

    // result count and flags, decided in the update cycle; dominance threshold product
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            if (r_req == REQ_ADD && (r_hit || r_has_free)) begin
                r_kc   <= w_cnew;
                r_full <= 1'b0;
                r_clip <= w_csum[CNT_W] || w_tsum[CNT_W];
            end else if (r_req == REQ_ADD) begin
                r_kc   <= '0;
                r_full <= 1'b1;
                r_clip <= 1'b0;
            end else begin
                r_kc   <= r_hit ? r_hit_cnt : '0;
                r_full <= 1'b0;
                r_clip <= 1'b0;
            end
        end
        if (i_cmd.dom_mul) begin
            r_rhs <= (CNT_W+THR_W)'(i_thr) * (CNT_W+THR_W)'(r_total);
        end
    end

    assign o_sts.scan_last = (r_evaled == CW'(TABLE_ENTRIES - 1));
    assign o_sts.hit       = r_hit;
    assign o_sts.is_add    = (r_req == REQ_ADD);
    assign o_sts.has_free  = r_has_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_key_count    <= r_kc;
            o_total_count  <= r_total;
            o_top_count    <= r_best_cnt;
            o_top_valid    <= (r_best_cnt != '0);
            o_top_key      <= (r_best_cnt != '0) ? w_top_key : '0;
            o_top_dominant <= (r_total != '0) &&
                              ({1'b0, r_best_cnt, {AMT_W{1'b0}}} > r_rhs);
            o_table_full   <= r_full;
            o_saturated    <= r_clip;
        end
    end

    a_clip_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && w_tsum[CNT_W]) |=> r_total == CNT_MAX)
        else $error("total did not saturate");
    a_best_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> r_best_cnt >= $past(w_cnew))
        else $error("best below updated count");
    a_evaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_eval |-> r_evaled < CW'(TABLE_ENTRIES))
        else $error("scan overrun");
endmodule

// ===== rtl/key_frequency_counter_table.sv =====
// top level of the key frequency counter table
//
// usage:
//   in channel carries one request word {req_type, key, amount}; req_type 0
//   adds amount to the key's count (inserting it into a free slot), 1 only reads it
//   out channel carries one result word per request: key count, running
//   total, top key and count, top valid, dominance, table full, saturated
//   apb port holds the dominance threshold (q1.16, 17 bits) at address 0
// lookup:
//   after accept the table is scanned, then the update, the dominance
//   product and the output register load follow in turn; the key lookup
//   reads the key and count memories one entry per cycle, set by the single
//   read port of each memory; one request is in flight at a time
// reset:
//   synchronous active low; used bits, total and best entry clear at once,
//   no clearing pass; threshold resets to zero
// stall:
//   the result sits in an output register until taken; the next request is
//   accepted meanwhile and waits only at its own result stage
module key_frequency_counter_table import kfct_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kfct_if.sink        i_req,
    kfct_if.source      o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic [THR_W-1:0] r_thr;

    // request word: {req_type, key, amount}
    logic             w_req_type;
    logic [31:0]      w_key;
    logic [AMT_W-1:0] w_amount;
    assign w_req_type = i_req.data[48];
    assign w_key      = i_req.data[47:16];
    assign w_amount   = i_req.data[15:0];

    // config register write
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD
                     && paddr[1:0] == 2'b00) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(32-THR_W){1'b0}}, r_thr} : '0;

    kfct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    // result word: {key_count, total_count, top_key, top_count,
    //               top_valid, top_dominant, table_full, saturated}
    kfct_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_req_type(w_req_type), .i_key(w_key), .i_amount(w_amount), .i_thr(r_thr),
        .o_key_count(o_rsp.data[131:100]), .o_total_count(o_rsp.data[99:68]),
        .o_top_key(o_rsp.data[67:36]), .o_top_count(o_rsp.data[35:4]),
        .o_top_valid(o_rsp.data[3]), .o_top_dominant(o_rsp.data[2]),
        .o_table_full(o_rsp.data[1]), .o_saturated(o_rsp.data[0])
    );
endmodule
